// ===== rtl/core/ols_pkg.sv =====
// Package for the ordered list store: operation and status codes, the control
// group that drives one list cell, and default sizes.
// No dependencies.
package ols_pkg;

   localparam int OLS_DEPTH     = 16;
   localparam int OLS_WORD_BITS = 32;

   localparam int OP_BITS     = 3;
   localparam int VALUE_BITS  = 32;
   localparam int POS_BITS    = 6;
   localparam int STATUS_BITS = 3;
   localparam int COUNT_BITS  = 5;

   localparam logic [VALUE_BITS-1:0] NEG_ONE = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_BACK    = 3'd0,
      OP_POP_BACK     = 3'd1,
      OP_PUSH_FRONT   = 3'd2,
      OP_POP_FRONT    = 3'd3,
      OP_INSERT_AFTER = 3'd4,
      OP_READ_AT      = 3'd5,
      OP_FIND         = 3'd6
   } ols_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_INDEX    = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } ols_status_type;

   // What one cell loads at the next edge; at most one bit is set.
   typedef struct packed {
      logic load_new;
      logic take_prev;
      logic take_next;
   } ols_cell_ctl_type;

endpackage

// ===== rtl/core/ols_if.sv =====
// Channel interfaces of the ordered list store: the request channel and the
// response channel, each with valid, ready and its payload. Uses ols_pkg.
interface ols_req_if import ols_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic        [OP_BITS-1:0]     operation;
   logic signed [VALUE_BITS-1:0]  value;
   logic signed [POS_BITS-1:0]    position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink   (input valid, input operation, input value, input position,
                   output ready);
endinterface

interface ols_rsp_if import ols_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_BITS-1:0]  result_word;
   logic        [STATUS_BITS-1:0] status;
   logic        [COUNT_BITS-1:0]  count;

   modport source (output valid, output result_word, output status, output count,
                   input ready);
   modport sink   (input valid, input result_word, input status, input count,
                   output ready);
endinterface

// ===== rtl/core/ols_cell.sv =====
// One slot of the list: holds a word, shifts it to or from its neighbors and
// compares it against the search key. Uses ols_pkg.
module ols_cell import ols_pkg::*; #(
   parameter int WORD_BITS = OLS_WORD_BITS
) (
   input  logic                        clock,
   input  ols_cell_ctl_type            ctl,
   input  logic signed [WORD_BITS-1:0] new_word,
   input  logic signed [WORD_BITS-1:0] prev_word,
   input  logic signed [WORD_BITS-1:0] next_word,
   input  logic signed [WORD_BITS-1:0] key,
   output logic signed [WORD_BITS-1:0] word,
   output logic                        hit
);

   logic signed [WORD_BITS-1:0] word_ff;
   logic signed [WORD_BITS-1:0] word_in;

   always_comb begin
      priority if (ctl.load_new) begin
         word_in = new_word;
      end else if (ctl.take_prev) begin
         word_in = prev_word;
      end else if (ctl.take_next) begin
         word_in = next_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign hit  = (word_ff == key);

endmodule

// ===== rtl/core/ols_pick.sv =====
// Picks the lowest selected cell: gives its index and its word, and whether any
// cell was selected at all. Uses ols_pkg.
module ols_pick import ols_pkg::*; #(
   parameter int DEPTH     = OLS_DEPTH,
   parameter int WORD_BITS = OLS_WORD_BITS,
   localparam int IW       = $clog2(DEPTH)
) (
   input  logic        [DEPTH-1:0]     sel,
   input  logic signed [WORD_BITS-1:0] words [DEPTH],
   output logic                        found,
   output logic        [IW-1:0]        index,
   output logic signed [WORD_BITS-1:0] word
);

   logic [DEPTH-1:0] first;

   // Isolate the lowest set bit with one two's-complement add.
   assign first = sel & (~sel + DEPTH'(1));
   assign found = |sel;

   always_comb begin
      index = '0;
      word  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            index = index | IW'(i);
            word  = word | words[i];
         end
      end
   end

endmodule

// ===== rtl/core/ordered_list_store.sv =====
// Top level of the ordered list store: the row of list cells, operation
// decode and the registered response. Uses ols_pkg, ols_if, ols_cell, ols_pick.
//
// The block keeps an ordered list of up to DEPTH signed words in a row of
// cells, one word per cell, with the entry count in a register. Each request
// beat carries one operation (push back, pop back, push front, pop front,
// insert after a position where -1 means the front, read at a position, or
// find the first position holding a value) and produces exactly one response
// beat with the popped or read word, the found index or -1, a status code and
// the count after the operation. The cells shift toward the back or the
// front all at once, and a find compares every cell against the key in
// parallel before a priority pick chooses the lowest hit, so a new request
// beat can be taken on every cycle while the request side is not stalled.
// The response sits in an output register from the cycle after its request;
// while that register holds a beat the sink has not taken, the request side
// is stalled. An insert or push into a full list is refused with the full
// status, a bad position with the index error status, and a pop from an
// empty list with the empty status; refused operations leave the list
// unchanged. Code 7 is answered with word 0 and status ok. Stored words keep
// their low WORD_BITS bits and come back sign-extended. The list is empty
// after reset; cell contents are never read before they are written.
module ordered_list_store import ols_pkg::*; #(
   parameter int DEPTH     = OLS_DEPTH,
   parameter int WORD_BITS = OLS_WORD_BITS
) (
   input  logic      clock,
   input  logic      reset,
   ols_req_if.sink   req_bus,
   ols_rsp_if.source rsp_bus
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   // Signed width that holds a position, a count and a count plus one.
   localparam int PW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic                          rsp_valid_ff;
   logic signed [VALUE_BITS-1:0]  rsp_word_ff;
   logic signed [VALUE_BITS-1:0]  rsp_word_in;
   ols_status_type                rsp_status_ff;
   ols_status_type                status_in;
   logic [CW-1:0]                 rsp_count_ff;

   logic req_accept;
   logic rsp_accept;

   ols_op_type op;
   logic signed [PW-1:0] pos_ext;
   logic signed [PW-1:0] count_ext;
   logic signed [PW-1:0] after_pos;
   logic signed [PW-1:0] slot_pos;
   logic signed [PW-1:0] rd_pos;
   logic                 is_insert;
   logic                 use_find;
   logic                 do_insert;
   logic                 do_pop_front;
   logic                 full;

   logic signed [WORD_BITS-1:0] store_word;
   logic signed [WORD_BITS-1:0] cell_word [DEPTH];
   logic        [DEPTH-1:0]     cell_hit;
   logic        [DEPTH-1:0]     pick_sel;
   logic                        pick_found;
   logic        [IW-1:0]        pick_index;
   logic signed [WORD_BITS-1:0] pick_word;

   // The output register frees up when it is empty or being drained.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_accept    = rsp_valid_ff && rsp_bus.ready;

   assign op         = ols_op_type'(req_bus.operation);
   assign pos_ext    = PW'(req_bus.position);
   assign count_ext  = signed'({{(PW - CW){1'b0}}, count_ff});
   assign full       = (count_ff == CW'(DEPTH));
   assign store_word = WORD_BITS'(req_bus.value);
   assign slot_pos   = after_pos + PW'(1);

   // Where an insert goes and which cell a read looks at.
   always_comb begin
      after_pos = pos_ext;
      rd_pos    = pos_ext;
      is_insert = 1'b0;
      use_find  = 1'b0;
      unique case (op)
         OP_PUSH_BACK: begin
            after_pos = count_ext - PW'(1);
            is_insert = 1'b1;
         end
         OP_PUSH_FRONT: begin
            after_pos = -PW'(1);
            is_insert = 1'b1;
         end
         OP_INSERT_AFTER: begin
            is_insert = 1'b1;
         end
         OP_POP_BACK: begin
            rd_pos = count_ext - PW'(1);
         end
         OP_POP_FRONT: begin
            rd_pos = '0;
         end
         OP_FIND: begin
            use_find = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Status, response word and the next count.
   always_comb begin
      do_insert    = 1'b0;
      do_pop_front = 1'b0;
      count_in     = count_ff;
      rsp_word_in  = '0;
      status_in    = ST_OK;
      if (is_insert) begin
         if (after_pos < -PW'(1) || after_pos >= count_ext) begin
            rsp_word_in = NEG_ONE;
            status_in   = ST_INDEX;
         end else if (full) begin
            rsp_word_in = NEG_ONE;
            status_in   = ST_FULL;
         end else begin
            do_insert = req_accept;
            count_in  = count_ff + CW'(1);
         end
      end else begin
         unique case (op)
            OP_POP_BACK, OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  rsp_word_in = NEG_ONE;
                  status_in   = ST_EMPTY;
               end else begin
                  rsp_word_in  = VALUE_BITS'(pick_word);
                  count_in     = count_ff - CW'(1);
                  do_pop_front = req_accept && (op == OP_POP_FRONT);
               end
            end
            OP_READ_AT: begin
               if (pos_ext < PW'(0) || pos_ext >= count_ext) begin
                  rsp_word_in = NEG_ONE;
                  status_in   = ST_INDEX;
               end else begin
                  rsp_word_in = VALUE_BITS'(pick_word);
               end
            end
            OP_FIND: begin
               if (pick_found) begin
                  rsp_word_in = signed'({{(VALUE_BITS - IW){1'b0}}, pick_index});
               end else begin
                  rsp_word_in = NEG_ONE;
                  status_in   = ST_NOTFOUND;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The row of cells. On an insert, cells above the slot up to the old count
   // take their lower neighbor and the slot takes the new word; on a pop from
   // the front, every occupied cell but the last takes its upper neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic signed [PW-1:0] CELL_POS = PW'(i);
      ols_cell_ctl_type            ctl;
      logic signed [WORD_BITS-1:0] prev_word;
      logic signed [WORD_BITS-1:0] next_word;

      assign ctl.load_new  = do_insert && (CELL_POS == slot_pos);
      assign ctl.take_prev = do_insert && (CELL_POS > slot_pos) && (CELL_POS <= count_ext);
      assign ctl.take_next = do_pop_front && (CELL_POS + PW'(1) < count_ext);

      if (i == 0) begin : g_first
         assign prev_word = store_word;
      end else begin : g_inner_prev
         assign prev_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_word = cell_word[i];
      end else begin : g_inner_next
         assign next_word = cell_word[i+1];
      end

      assign pick_sel[i] = use_find ? (cell_hit[i] && (CELL_POS < count_ext))
                                    : (rd_pos == CELL_POS);

      ols_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_word  (store_word),
         .prev_word (prev_word),
         .next_word (next_word),
         .key       (store_word),
         .word      (cell_word[i]),
         .hit       (cell_hit[i])
      );
   end

   ols_pick #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_pick (
      .sel   (pick_sel),
      .words (cell_word),
      .found (pick_found),
      .index (pick_index),
      .word  (pick_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff   <= rsp_word_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_word = rsp_word_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.count       = COUNT_BITS'(rsp_count_ff);

   // The count never passes the capacity of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above capacity");

   // A refused operation leaves the count where it was.
   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && status_in != ST_OK |=> count_ff == $past(count_ff))
      else $error("refused operation changed the count");

   // An accepted beat moves the count by at most one entry.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (count_ff == $past(count_ff))
                  || (count_ff == CW'($past(count_ff) + CW'(1)))
                  || (CW'(count_ff + CW'(1)) == $past(count_ff)))
      else $error("count moved by more than one entry");

endmodule

// ===== test/ols_tb_pkg.sv =====
// Checking side of the ordered list store testbench: the result beat type
// and a scoreboard that predicts each response from the accepted requests.
// Depends on ols_pkg.
`timescale 1ns / 1ps

package ols_tb_pkg;
   import ols_pkg::*;

   // Code 7 has no name in the operation enum; the block answers it with ok.
   localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  word;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  count;
   } list_result_type;

   class list_scoreboard;
      logic [VALUE_BITS-1:0] slots [OLS_DEPTH];
      int                    fill;
      list_result_type       expected_q [$];
      int                    errors;
      int                    checked;
      int                    op_count [8];
      int                    status_count [5];
      int                    full_hits;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         full_hits = 0;
         foreach (op_count[i]) op_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void flag(string msg);
         errors++;
         $display("%s", msg);
      endfunction

      // Applies one accepted request beat to the shadow list and queues the
      // response it must produce.
      function void note_request(logic [OP_BITS-1:0] op, logic [VALUE_BITS-1:0] val,
                                 logic [POS_BITS-1:0] pos);
         list_result_type res;
         int              after;
         int              k;
         int              idx;
         res.word   = '0;
         res.status = ST_OK;
         idx        = int'($signed(pos));
         case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AFTER: begin
               if (op == OP_PUSH_BACK)
                  after = fill - 1;
               else if (op == OP_PUSH_FRONT)
                  after = -1;
               else
                  after = idx;
               // The position is judged before fullness.
               if (after < -1 || after >= fill) begin
                  res.word   = NEG_ONE;
                  res.status = ST_INDEX;
               end else if (fill >= OLS_DEPTH) begin
                  res.word   = NEG_ONE;
                  res.status = ST_FULL;
               end else begin
                  for (k = fill; k > after + 1; k--)
                     slots[k] = slots[k-1];
                  slots[after+1] = val;
                  fill++;
                  if (fill == OLS_DEPTH)
                     full_hits++;
               end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
               if (fill == 0) begin
                  res.word   = NEG_ONE;
                  res.status = ST_EMPTY;
               end else if (op == OP_POP_BACK) begin
                  res.word = slots[fill-1];
                  fill--;
               end else begin
                  res.word = slots[0];
                  for (k = 0; k + 1 < fill; k++)
                     slots[k] = slots[k+1];
                  fill--;
               end
            end
            OP_READ_AT: begin
               if (idx < 0 || idx >= fill) begin
                  res.word   = NEG_ONE;
                  res.status = ST_INDEX;
               end else begin
                  res.word = slots[idx];
               end
            end
            OP_FIND: begin
               res.word   = NEG_ONE;
               res.status = ST_NOTFOUND;
               for (k = fill - 1; k >= 0; k--) begin
                  if (slots[k] == val) begin
                     res.word   = VALUE_BITS'(k);
                     res.status = ST_OK;
                  end
               end
            end
            default: ;
         endcase
         res.count = COUNT_BITS'(fill);
         op_count[op]++;
         status_count[res.status]++;
         expected_q.insert(expected_q.size(), res);
      endfunction

      function void check_response(logic [VALUE_BITS-1:0]  word,
                                   logic [STATUS_BITS-1:0] status,
                                   logic [COUNT_BITS-1:0]  count);
         list_result_type exp;
         if (expected_q.size() == 0) begin
            flag($sformatf("%0t: unexpected response beat: word %h status %0d count %0d",
                           $time, word, status, count));
            return;
         end
         exp = expected_q[0];
         expected_q.delete(0);
         checked++;
         if (word !== exp.word)
            flag($sformatf("%0t: result_word expected %h actual %h", $time, exp.word, word));
         if (status !== exp.status)
            flag($sformatf("%0t: status expected %0d actual %0d", $time, exp.status, status));
         if (count !== exp.count)
            flag($sformatf("%0t: count expected %0d actual %0d", $time, exp.count, count));
      endfunction

      function void report();
         $display("Run covered %0d push/insert, %0d pop, %0d read, %0d find and %0d code-7 beats;",
                  op_count[OP_PUSH_BACK] + op_count[OP_PUSH_FRONT] + op_count[OP_INSERT_AFTER],
                  op_count[OP_POP_BACK] + op_count[OP_POP_FRONT], op_count[OP_READ_AT],
                  op_count[OP_FIND], op_count[OP_UNUSED]);
         $display("%0d responses checked (ok %0d, index %0d, empty %0d, not found %0d,",
                  checked, status_count[ST_OK], status_count[ST_INDEX], status_count[ST_EMPTY],
                  status_count[ST_NOTFOUND]);
         $display("full %0d), list full %0d times.", status_count[ST_FULL], full_hits);
      endfunction
   endclass

endpackage

// ===== test/tb.sv =====
// Top of the ordered list store testbench: clock, reset, request driver and
// response sink around one instance of the block.
// Depends on ols_pkg, ols_if, ols_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import ols_pkg::*;
   import ols_tb_pkg::*;

   localparam int RANDOM_ITEMS = 600;

   // The response sink moves between a few stall patterns of its own.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_PERIODIC
   } sink_mode_type;

   logic           clock;
   logic           reset;
   logic           sink_ready = 1'b0;
   sink_mode_type  sink_mode  = RX_ALWAYS;
   int             sink_left  = 0;
   int             sink_phase = 0;
   int             sink_period = 8;
   bit             fill_rising = 1'b1;
   list_scoreboard sb;

   ols_req_if req_bus ();
   ols_rsp_if rsp_bus ();

   ordered_list_store DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   assign rsp_bus.ready = sink_ready;

   // Response sink. Every so often it picks a new stall pattern: always
   // ready, a coin toss, mostly stalled, or a fixed duty cycle with a random
   // period, so that stalls land on every phase of the request stream.
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         sink_left  <= 0;
      end else begin
         if (sink_left == 0) begin
            sink_mode   <= sink_mode_type'($urandom_range(0, 3));
            sink_left   <= $urandom_range(20, 120);
            sink_period <= $urandom_range(3, 12);
         end else begin
            sink_left <= sink_left - 1;
         end
         sink_phase <= sink_phase + 1;
         case (sink_mode)
            RX_ALWAYS:   sink_ready <= 1'b1;
            RX_RANDOM:   sink_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   sink_ready <= ($urandom_range(0, 3) == 0);
            default:     sink_ready <= ((sink_phase % sink_period) < 2);
         endcase
      end
   end

   // Every response beat taken at this edge is checked against the oldest
   // prediction. The values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.result_word, rsp_bus.status, rsp_bus.count);
   end

   // Presents one request beat and holds it until the block takes it. The
   // scoreboard is updated right at the accepting edge, so the stimulus that
   // follows can look at the list as it now stands.
   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [VALUE_BITS-1:0] val,
                            input logic [POS_BITS-1:0] pos);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= val;
      req_bus.position  <= pos;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_request(op, val, pos);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds off the sender until every outstanding response beat is back.
   task automatic drain_list_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Words come mostly from a small pool so that finds hit and duplicates
   // exist, with the extremes and fully random words mixed in.
   function automatic logic [VALUE_BITS-1:0] pick_word();
      case ($urandom_range(0, 4))
         0, 1: return VALUE_BITS'(int'($urandom_range(0, 7)) - 4);
         2: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // One random request. The list alternates between a filling tide and a
   // draining tide so that both the full and the empty ends are reached
   // often; most requests use legal positions and a tenth is pure noise.
   task automatic random_item();
      int                    f;
      int                    pick;
      logic [OP_BITS-1:0]    op;
      logic [VALUE_BITS-1:0] val;
      logic [POS_BITS-1:0]   pos;
      f = sb.fill;
      if (f == OLS_DEPTH)
         fill_rising = 1'b0;
      else if (f == 0)
         fill_rising = 1'b1;
      else if ($urandom_range(0, 19) == 0)
         fill_rising = !fill_rising;
      val  = pick_word();
      pos  = POS_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         op  = OP_BITS'($urandom_range(0, 7));
         val = $urandom;
      end else if (pick < (fill_rising ? 55 : 25)) begin
         case ($urandom_range(0, 2))
            0:       op = OP_PUSH_BACK;
            1:       op = OP_PUSH_FRONT;
            default: begin
               op  = OP_INSERT_AFTER;
               pos = POS_BITS'($urandom_range(0, f) - 1);
            end
         endcase
      end else if (pick < 70) begin
         op = ($urandom_range(0, 1) == 1) ? OP_POP_BACK : OP_POP_FRONT;
      end else if (pick < 85) begin
         op = OP_READ_AT;
         if (f > 0)
            pos = POS_BITS'($urandom_range(0, f - 1));
      end else begin
         op = OP_FIND;
         if (f > 0 && $urandom_range(0, 2) != 0)
            val = sb.slots[$urandom_range(0, f - 1)];
      end
      send_item(op, val, pos);
   endtask

   initial begin
      int burst_left;
      int i;
      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_PUSH_BACK;
      req_bus.value     <= '0;
      req_bus.position  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats. On the empty list: both pops, a read, a find and an
      // insert at a position that does not exist yet, then code 7.
      send_item(OP_POP_BACK, '0, '0);
      send_item(OP_POP_FRONT, '0, '0);
      send_item(OP_READ_AT, '0, '0);
      send_item(OP_FIND, 32'd5, '0);
      send_item(OP_INSERT_AFTER, 32'd9, 6'd0);
      send_item(OP_UNUSED, '1, '1);
      // Build the list -1, min, max, 0 from the extremes, using insert at the
      // front (position -1), both pushes and an insert at the very end.
      send_item(OP_INSERT_AFTER, 32'h8000_0000, '1);
      send_item(OP_PUSH_BACK, 32'h7FFF_FFFF, '0);
      send_item(OP_PUSH_FRONT, '1, '0);
      send_item(OP_INSERT_AFTER, '0, 6'd2);
      send_item(OP_READ_AT, '0, 6'd4);
      send_item(OP_FIND, 32'h7FFF_FFFF, '0);
      // Fill up with inserts in the middle until the list is full.
      for (i = 0; i < OLS_DEPTH - 4; i++)
         send_item(OP_INSERT_AFTER, VALUE_BITS'(i * 1000 + 7), POS_BITS'(sb.fill / 2));
      // On the full list a bad position is reported before fullness.
      send_item(OP_PUSH_FRONT, 32'd3, '0);
      send_item(OP_INSERT_AFTER, 32'd3, 6'd20);
      send_item(OP_INSERT_AFTER, 32'd3, 6'd15);
      send_item(OP_POP_FRONT, '0, '0);
      drain_list_results();

      // Random beats in bursts with random gaps; halfway through the sender
      // waits for every response once more.
      burst_left = $urandom_range(1, 24);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         random_item();
         if (i == RANDOM_ITEMS / 2) begin
            drain_list_results();
         end else if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end

      drain_list_results();
      repeat (8) @(posedge clock);
      sb.report();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
